/* hw/rtl/pidtm_pkg.sv */
// pidtm_pkg: shared widths, codes, state encoding and interface structs
// for the two-mode pid controller. Used by every module under hw/rtl.
`timescale 1ns / 1ps

package pidtm_pkg;

	// fixed point layout, Q16.16 data and a wider integral
	localparam int DATA_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int ACC_W   = 48;
	localparam int SUM_W   = 64;
	localparam int MUL_B_W = DATA_W + 2;
	localparam int PROD_W  = DATA_W + MUL_B_W;
	localparam int SPLIT_W = ACC_W / 2;
	localparam int HI_SH   = SPLIT_W - FRAC_W;
	localparam int BETA_W  = 17;
	localparam int IDX_W   = 3;

	// one in Q1.16 for the derivative filter coefficient
	localparam logic [BETA_W-1:0] BETA_ONE = BETA_W'(1) << FRAC_W;

	// input command and mode codes
	localparam logic CMD_CLEAR  = 1'b1;
	localparam logic MODE_INCR  = 1'b1;

	// register map
	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_FILTER_BETA  = 3'd3,
		REG_OUTPUT_UPPER = 3'd4,
		REG_OUTPUT_LOWER = 3'd5,
		REG_TARGET_VALUE = 3'd6,
		REG_CALC_MODE    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] kp;
		logic signed [DATA_W-1:0] ki;
		logic signed [DATA_W-1:0] kd;
		logic [BETA_W-1:0]        beta;
		logic signed [DATA_W-1:0] upper;
		logic signed [DATA_W-1:0] lower;
		logic signed [DATA_W-1:0] target;
		logic                     mode;
	} cfg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_P5,
		ST_I0,
		ST_I1,
		ST_I2,
		ST_I3,
		ST_FIN
	} state_t;

	// operand pair for the shared multiplier
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_BETA,
		MUL_KP_E,
		MUL_KD_D,
		MUL_KI_IL,
		MUL_KI_IH,
		MUL_KP_DE,
		MUL_KD_DDE,
		MUL_KI_E
	} mul_op_t;

	// what happens to the previous product
	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_ZERO,
		ACC_PREV,
		ACC_DERIV,
		ACC_LOW,
		ACC_HIGH
	} acc_op_t;

	typedef struct packed {
		logic    load;
		logic    clear;
		mul_op_t mul_op;
		acc_op_t acc_op;
		logic    integ_upd;
		logic    finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic incremental;
	} dp_sts_t;

endpackage

/* hw/rtl/pid_controller_two_mode.sv */
// pid_controller_two_mode: top level of the two-mode pid controller.
// Depends on pidtm_pkg, pidtm_cfg, pidtm_ctrl and pidtm_dpath.
//
// channel   direction  handshake                  payload
// sample    in         sample_valid/sample_stall  command, measurement
// drive     out        drive_valid/drive_stall    control_out
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// a positional step runs states P0 to P5 and an incremental step I0 to I3,
// each then FIN; the steps are set by the one shared 32x34 multiplier,
// used once per product, with the accumulate in the state after it.
// a clear word gives no result and leaves the sequencer idle.
// a finished result waits in the output register; a new sample is taken
// meanwhile, and only the final write-back waits while drive_stall holds.
// reset clears history, the last output and the registers to their defaults.
`timescale 1ns / 1ps

module pid_controller_two_mode import pidtm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  logic                     command,
	input  logic signed [DATA_W-1:0] measurement,
	output logic                     drive_valid,
	input  logic                     drive_stall,
	output logic signed [DATA_W-1:0] control_out,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	cfg_t      cfg;
	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// configuration registers
	pidtm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	pidtm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.command      (command),
		.sample_stall (sample_stall),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// arithmetic
	pidtm_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.measurement (measurement),
		.sts         (sts),
		.control_out (control_out)
	);

endmodule

/* hw/rtl/pidtm_cfg.sv */
// pidtm_cfg: configuration register file with its write port.
// Depends on pidtm_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps

module pidtm_cfg import pidtm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t regs_q;

	// writes always taken
	assign cfg_ready = 1'b1;
	assign cfg        = regs_q;

	// register writes, each masked to its own width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kp     <= '0;
			regs_q.ki     <= '0;
			regs_q.kd     <= '0;
			regs_q.beta   <= '0;
			regs_q.upper  <= {1'b0, {(DATA_W-1){1'b1}}};
			regs_q.lower  <= {1'b1, {(DATA_W-1){1'b0}}};
			regs_q.target <= '0;
			regs_q.mode   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:    regs_q.kp     <= cfg_data;
				REG_INTEG_GAIN:   regs_q.ki     <= cfg_data;
				REG_DERIV_GAIN:   regs_q.kd     <= cfg_data;
				REG_FILTER_BETA:  regs_q.beta   <= cfg_data[BETA_W-1:0];
				REG_OUTPUT_UPPER: regs_q.upper  <= cfg_data;
				REG_OUTPUT_LOWER: regs_q.lower  <= cfg_data;
				REG_TARGET_VALUE: regs_q.target <= cfg_data;
				REG_CALC_MODE:    regs_q.mode   <= cfg_data[0];
				default:          regs_q        <= regs_q;
			endcase
		end
	end

endmodule

/* hw/rtl/pidtm_ctrl.sv */
// pidtm_ctrl: sequencer that steps the shared multiplier through one
// control step and owns the sample and drive handshakes. Depends on pidtm_pkg.
`timescale 1ns / 1ps

module pidtm_ctrl import pidtm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	input  logic      command,
	output logic      sample_stall,
	output logic      drive_valid,
	input  logic      drive_stall,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   drive_valid_q;
	logic   accept;
	logic   fire;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	// result slot free, or emptied at this edge
	assign fire         = !(drive_valid_q && drive_stall);
	assign drive_valid  = drive_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && command != CMD_CLEAR) begin
					state_d = sts.incremental ? ST_I0 : ST_P0;
				end
			end
			ST_P0: state_d = ST_P1;
			ST_P1: state_d = ST_P2;
			ST_P2: state_d = ST_P3;
			ST_P3: state_d = ST_P4;
			ST_P4: state_d = ST_P5;
			ST_P5: state_d = ST_FIN;
			ST_I0: state_d = ST_I1;
			ST_I1: state_d = ST_I2;
			ST_I2: state_d = ST_I3;
			ST_I3: state_d = ST_FIN;
			ST_FIN: begin
				if (fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.mul_op    = MUL_NONE;
		cmd.acc_op    = ACC_NONE;
		cmd.load      = accept && command != CMD_CLEAR;
		cmd.clear     = accept && command == CMD_CLEAR;
		case (state_q)
			ST_P0: begin
				cmd.mul_op    = MUL_BETA;
				cmd.acc_op    = ACC_ZERO;
				cmd.integ_upd = 1'b1;
			end
			ST_P1: begin
				cmd.mul_op = MUL_KP_E;
				cmd.acc_op = ACC_DERIV;
			end
			ST_P2: begin
				cmd.mul_op = MUL_KD_D;
				cmd.acc_op = ACC_LOW;
			end
			ST_P3: begin
				cmd.mul_op = MUL_KI_IL;
				cmd.acc_op = ACC_LOW;
			end
			ST_P4: begin
				cmd.mul_op = MUL_KI_IH;
				cmd.acc_op = ACC_LOW;
			end
			ST_P5: cmd.acc_op = ACC_HIGH;
			ST_I0: begin
				cmd.mul_op = MUL_KP_DE;
				cmd.acc_op = ACC_PREV;
			end
			ST_I1: begin
				cmd.mul_op = MUL_KD_DDE;
				cmd.acc_op = ACC_LOW;
			end
			ST_I2: begin
				cmd.mul_op = MUL_KI_E;
				cmd.acc_op = ACC_LOW;
			end
			ST_I3: cmd.acc_op = ACC_LOW;
			ST_FIN: cmd.finish = fire;
			default: cmd.acc_op = ACC_NONE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			drive_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				drive_valid_q <= 1'b1;
			end else if (!drive_stall) begin
				drive_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/pidtm_dpath.sv */
// pidtm_dpath: error, history, integral, shared multiplier, accumulator
// and output clamp. Depends on pidtm_pkg; driven by pidtm_ctrl.
`timescale 1ns / 1ps

module pidtm_dpath import pidtm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_cmd_t                cmd,
	input  cfg_t                     cfg,
	input  logic signed [DATA_W-1:0] measurement,
	output dp_sts_t                  sts,
	output logic signed [DATA_W-1:0] control_out
);

	localparam logic signed [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] D_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]  A_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  A_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// saturate a one-bit-wider difference to data width
	function automatic logic signed [DATA_W-1:0] sat_err(input logic signed [DATA_W:0] x);
		if (x[DATA_W] == x[DATA_W-1]) begin
			return x[DATA_W-1:0];
		end
		return x[DATA_W] ? D_MIN : D_MAX;
	endfunction

	// saturate the filter result, four guard bits
	function automatic logic signed [DATA_W-1:0] sat_drv(input logic signed [DATA_W+3:0] x);
		logic [4:0] top;
		top = x[DATA_W+3:DATA_W-1];
		if (&top || !(|top)) begin
			return x[DATA_W-1:0];
		end
		return x[DATA_W+3] ? D_MIN : D_MAX;
	endfunction

	// saturate the integral update
	function automatic logic signed [ACC_W-1:0] sat_int(input logic signed [ACC_W:0] x);
		if (x[ACC_W] == x[ACC_W-1]) begin
			return x[ACC_W-1:0];
		end
		return x[ACC_W] ? A_MIN : A_MAX;
	endfunction

	// history (architectural state)
	logic signed [DATA_W-1:0] err1_q, err2_q, dprev_q, iprev_q, last_q;
	logic signed [ACC_W-1:0]  integ_q;
	// working registers
	logic signed [DATA_W-1:0] err_q, deriv_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [DATA_W:0]    err_diff;
	logic signed [DATA_W:0]    diff;
	logic signed [MUL_B_W-1:0] ddiff;
	logic signed [MUL_B_W-1:0] dp_diff;
	logic [BETA_W-1:0]         beta_c;
	logic signed [DATA_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [PROD_W-1:0]  prod_fl;
	logic signed [DATA_W+3:0]  dsum;
	logic signed [ACC_W:0]     isum;
	logic                      integ_ok;
	logic signed [SUM_W-1:0]   up_x, lo_x, lim_hi, lim_lo;
	logic signed [DATA_W-1:0]  y;

	assign sts.incremental = (cfg.mode == MODE_INCR);
	assign control_out     = last_q;

	// error of the new sample
	assign err_diff = {cfg.target[DATA_W-1], cfg.target}
		- {measurement[DATA_W-1], measurement};

	// first and second differences of the error
	assign diff  = {err_q[DATA_W-1], err_q} - {err1_q[DATA_W-1], err1_q};
	assign ddiff = {{2{err_q[DATA_W-1]}}, err_q} - {err1_q[DATA_W-1], err1_q, 1'b0}
		+ {{2{err2_q[DATA_W-1]}}, err2_q};

	// filter as diff + beta*(dprev - diff), beta capped at one
	assign beta_c  = (cfg.beta > BETA_ONE) ? BETA_ONE : cfg.beta;
	assign dp_diff = {{2{dprev_q[DATA_W-1]}}, dprev_q} - {diff[DATA_W], diff};

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			MUL_BETA: begin
				mul_a = $signed({{(DATA_W-BETA_W){1'b0}}, beta_c});
				mul_b = dp_diff;
			end
			MUL_KP_E: begin
				mul_a = cfg.kp;
				mul_b = {{2{err_q[DATA_W-1]}}, err_q};
			end
			MUL_KD_D: begin
				mul_a = cfg.kd;
				mul_b = {{2{deriv_q[DATA_W-1]}}, deriv_q};
			end
			MUL_KI_IL: begin
				mul_a = cfg.ki;
				mul_b = $signed({{(MUL_B_W-SPLIT_W){1'b0}}, integ_q[SPLIT_W-1:0]});
			end
			MUL_KI_IH: begin
				mul_a = cfg.ki;
				mul_b = {{(MUL_B_W-(ACC_W-SPLIT_W)){integ_q[ACC_W-1]}},
					integ_q[ACC_W-1:SPLIT_W]};
			end
			MUL_KP_DE: begin
				mul_a = cfg.kp;
				mul_b = {diff[DATA_W], diff};
			end
			MUL_KD_DDE: begin
				mul_a = cfg.kd;
				mul_b = ddiff;
			end
			MUL_KI_E: begin
				mul_a = cfg.ki;
				mul_b = {{2{err_q[DATA_W-1]}}, err_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d  = mul_a * mul_b;
	// floor of the product in Q16.16
	assign prod_fl = prod_q >>> FRAC_W;
	assign dsum    = {{3{diff[DATA_W]}}, diff} + prod_fl[DATA_W+3:0];

	// integral anti-windup gate
	assign integ_ok = (last_q < cfg.upper && last_q > cfg.lower)
		|| (err_q > 0 && last_q < cfg.upper)
		|| (err_q < 0 && last_q > cfg.lower);
	assign isum = {integ_q[ACC_W-1], integ_q}
		+ {{(ACC_W-DATA_W+1){err_q[DATA_W-1]}}, err_q};

	// clamp, upper first so the lower limit wins when they cross
	assign up_x   = {{(SUM_W-DATA_W){cfg.upper[DATA_W-1]}}, cfg.upper};
	assign lo_x   = {{(SUM_W-DATA_W){cfg.lower[DATA_W-1]}}, cfg.lower};
	assign lim_hi = (sum_q > up_x) ? up_x : sum_q;
	assign lim_lo = (lim_hi < lo_x) ? lo_x : lim_hi;
	assign y      = lim_lo[DATA_W-1:0];

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.load) begin
			err_q <= sat_err(err_diff);
		end
		case (cmd.acc_op)
			ACC_ZERO:  sum_q   <= '0;
			ACC_PREV:  sum_q   <= {{(SUM_W-DATA_W){iprev_q[DATA_W-1]}}, iprev_q};
			ACC_DERIV: deriv_q <= sat_drv(dsum);
			ACC_LOW:   sum_q   <= sum_q + prod_fl[SUM_W-1:0];
			ACC_HIGH:  sum_q   <= sum_q + {prod_q[SUM_W-HI_SH-1:0], {HI_SH{1'b0}}};
			default:   sum_q   <= sum_q;
		endcase
	end

	// history, integral and last output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err1_q  <= '0;
			err2_q  <= '0;
			dprev_q <= '0;
			iprev_q <= '0;
			last_q  <= '0;
			integ_q <= '0;
		end else if (cmd.clear) begin
			err1_q  <= '0;
			err2_q  <= '0;
			dprev_q <= '0;
			iprev_q <= '0;
			integ_q <= '0;
		end else begin
			if (cmd.integ_upd && integ_ok) begin
				integ_q <= sat_int(isum);
			end
			if (cmd.finish) begin
				last_q <= y;
				err1_q <= err_q;
				if (sts.incremental) begin
					err2_q  <= err1_q;
					iprev_q <= y;
				end else begin
					dprev_q <= deriv_q;
				end
			end
		end
	end

endmodule

/* test/tb.sv */
// tb: self-checking bench for pid_controller_two_mode. Directed words first, then
// random phases with fresh register settings and varied idling on both sides.
// Depends on pidtm_pkg and the rtl under hw/rtl.
`timescale 1ns / 1ps

module tb;
	import pidtm_pkg::*;

	localparam logic CMD_STEP = ~CMD_CLEAR;
	localparam logic MODE_POS = ~MODE_INCR;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_WORDS = 100;
	localparam logic [DATA_W-1:0] MAX_Q = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] MIN_Q = 32'h8000_0000;
	localparam logic [DATA_W-1:0] ONE_Q = 32'h0001_0000;

	// predicts control_out for every accepted step word and checks the drive side
	class pid_drive_tracker;
		longint kp, ki, kd, upper, lower, target;
		logic [BETA_W-1:0] beta;
		logic mode;
		longint integ_acc, err_d1, err_d2, deriv_filt, incr_out, held_out;
		logic signed [DATA_W-1:0] drive_due[$];
		int mismatches;

		function new();
			kp = 0;
			ki = 0;
			kd = 0;
			beta = '0;
			mode = MODE_POS;
			upper = $signed(MAX_Q);
			lower = $signed(MIN_Q);
			target = 0;
			integ_acc = 0;
			err_d1 = 0;
			err_d2 = 0;
			deriv_filt = 0;
			incr_out = 0;
			held_out = 0;
			mismatches = 0;
		endfunction

		// saturate to a signed width of w bits
		function longint sat_bits(logic signed [127:0] x, int w);
			logic signed [127:0] hi, lo;
			hi = (128'sd1 <<< (w - 1)) - 128'sd1;
			lo = -hi - 128'sd1;
			if (x > hi)
				x = hi;
			else if (x < lo)
				x = lo;
			return x[63:0];
		endfunction

		// exact product, floor shift by the fraction bits, 64-bit saturation
		function longint qmul(longint a, longint b);
			logic signed [127:0] wa, wb;
			wa = a;
			wb = b;
			return sat_bits((wa * wb) >>> FRAC_W, 64);
		endfunction

		function longint qadd(longint a, longint b);
			logic signed [127:0] wa, wb;
			wa = a;
			wb = b;
			return sat_bits(wa + wb, 64);
		endfunction

		function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_PROP_GAIN:    kp = $signed(val);
				REG_INTEG_GAIN:   ki = $signed(val);
				REG_DERIV_GAIN:   kd = $signed(val);
				REG_FILTER_BETA:  beta = val[BETA_W-1:0];
				REG_OUTPUT_UPPER: upper = $signed(val);
				REG_OUTPUT_LOWER: lower = $signed(val);
				REG_TARGET_VALUE: target = $signed(val);
				REG_CALC_MODE:    mode = val[0];
				default: ;
			endcase
		endfunction

		function void take_sample(logic cmd, logic signed [DATA_W-1:0] meas);
			longint e, d, y, b;
			// clear wipes the history but keeps the last output
			if (cmd == CMD_CLEAR) begin
				integ_acc = 0;
				err_d1 = 0;
				err_d2 = 0;
				deriv_filt = 0;
				incr_out = 0;
				return;
			end
			e = sat_bits(target - longint'(meas), DATA_W);
			if (mode == MODE_POS) begin
				b = (beta > BETA_ONE) ? longint'(BETA_ONE) : longint'(beta);
				// anti-windup: integrate only inside the limits or when heading back in
				if ((held_out < upper && held_out > lower) ||
						(e > 0 && held_out < upper) || (e < 0 && held_out > lower))
					integ_acc = sat_bits(integ_acc + e, ACC_W);
				d = b * deriv_filt + (longint'(BETA_ONE) - b) * (e - err_d1);
				d = sat_bits(d >>> FRAC_W, DATA_W);
				y = qadd(qmul(kp, e), qmul(kd, d));
				y = qadd(y, qmul(ki, integ_acc));
				err_d1 = e;
				deriv_filt = d;
			end else begin
				y = qadd(qmul(kp, e - err_d1), qmul(kd, e - 2 * err_d1 + err_d2));
				y = qadd(y, qmul(ki, e));
				y = qadd(y, incr_out);
				err_d2 = err_d1;
				err_d1 = e;
			end
			// upper first, so a crossed lower limit wins
			if (y > upper)
				y = upper;
			if (y < lower)
				y = lower;
			if (mode == MODE_INCR)
				incr_out = y;
			held_out = y;
			drive_due.push_back(y[DATA_W-1:0]);
		endfunction

		function void check_drive(logic signed [DATA_W-1:0] got);
			logic signed [DATA_W-1:0] want;
			if (drive_due.size() == 0) begin
				$error("control_out: no result expected, got %0d", got);
				mismatches++;
				return;
			end
			want = drive_due.pop_front();
			if (got !== want) begin
				$error("control_out: expected %0d, got %0d", want, got);
				mismatches++;
			end
		endfunction

		function int pending();
			return drive_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	logic command;
	logic signed [DATA_W-1:0] measurement;
	logic drive_valid;
	logic drive_stall;
	logic signed [DATA_W-1:0] control_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	pid_drive_tracker trk;
	int in_idle_pct;
	int out_idle_pct;
	int cycles = 0;
	logic [DATA_W-1:0] cur_target;

	pid_controller_two_mode u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.command      (command),
		.measurement  (measurement),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.control_out  (control_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// drive side: check every accepted word
	always @(posedge clk) begin
		if (arst_n && drive_valid && !drive_stall)
			trk.check_drive(control_out);
	end

	// drive side back-pressure in random bursts
	initial begin
		int left;
		left = 0;
		drive_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (left > 0) begin
				drive_stall <= 1'b1;
				left--;
			end else if ($urandom_range(99) < out_idle_pct) begin
				drive_stall <= 1'b1;
				left = $urandom_range(16);
			end else begin
				drive_stall <= 1'b0;
			end
		end
	end

	task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		trk.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic cfg_write_all(logic [DATA_W-1:0] g_p, logic [DATA_W-1:0] g_i,
			logic [DATA_W-1:0] g_d, logic [DATA_W-1:0] b, logic [DATA_W-1:0] up,
			logic [DATA_W-1:0] lo, logic [DATA_W-1:0] tgt, logic [DATA_W-1:0] md);
		cfg_write(REG_PROP_GAIN, g_p);
		cfg_write(REG_INTEG_GAIN, g_i);
		cfg_write(REG_DERIV_GAIN, g_d);
		cfg_write(REG_FILTER_BETA, b);
		cfg_write(REG_OUTPUT_UPPER, up);
		cfg_write(REG_OUTPUT_LOWER, lo);
		cfg_write(REG_TARGET_VALUE, tgt);
		cfg_write(REG_CALC_MODE, md);
		cur_target = tgt;
	endtask

	// one sample word, with an optional idle burst ahead of it
	task automatic send_word(logic cmd, logic [DATA_W-1:0] meas);
		int gap;
		gap = ($urandom_range(99) < in_idle_pct) ? $urandom_range(17, 1) : 0;
		if (gap != 0) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		command      <= cmd;
		measurement  <= meas;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		trk.take_sample(cmd, meas);
	endtask

	// drop valid, drain the results, then give the block time to finish
	task automatic settle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (trk.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_gain();
		case ($urandom_range(9))
			0: return '0;
			1: return MAX_Q;
			2: return MIN_Q;
			3: return $urandom;
			default: return $urandom_range(4 << 16) - (2 << 16);
		endcase
	endfunction

	task automatic cfg_random();
		logic [DATA_W-1:0] up, lo, tgt, b;
		case ($urandom_range(9))
			0: begin
				up = MAX_Q;
				lo = MIN_Q;
			end
			// crossed limits
			1: begin
				lo = $urandom_range(20 << 16);
				up = lo - $urandom_range(20 << 16, 1);
			end
			2: begin
				up = $urandom;
				lo = $urandom;
			end
			default: begin
				up = $urandom_range(2000 << 16, 1);
				lo = -$urandom_range(2000 << 16, 1);
			end
		endcase
		case ($urandom_range(5))
			0: b = '0;
			1: b = BETA_ONE;
			2: b = $urandom_range(131071, 65537);
			default: b = $urandom_range(65536);
		endcase
		// junk above the register width must be dropped
		b = b | ($urandom << BETA_W);
		case ($urandom_range(7))
			0: tgt = MAX_Q;
			1: tgt = MIN_Q;
			default: tgt = $urandom_range(200 << 16) - (100 << 16);
		endcase
		cfg_write_all(pick_gain(), pick_gain(), pick_gain(), b, up, lo, tgt, $urandom);
	endtask

	task automatic send_random();
		logic [DATA_W-1:0] m;
		case ($urandom_range(19))
			0: m = MAX_Q;
			1: m = MIN_Q;
			2, 3: m = $urandom;
			default: m = cur_target + $urandom_range(100 << 16) - (50 << 16);
		endcase
		send_word(($urandom_range(24) == 0) ? CMD_CLEAR : CMD_STEP, m);
	endtask

	initial begin
		trk = new();
		arst_n = 1'b0;
		sample_valid = 1'b0;
		command = CMD_STEP;
		measurement = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PROP_GAIN;
		cfg_data = '0;
		cur_target = '0;
		in_idle_pct = 30;
		out_idle_pct = 30;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: zero gains keep the output at zero
		send_word(CMD_STEP, '0);
		send_word(CMD_STEP, MAX_Q);
		settle();

		// positional, saturating errors push into both limits, then a clear
		cfg_write_all(ONE_Q, ONE_Q >> 1, ONE_Q >> 2, 32'h0000_8000, 10 << 16, -(10 << 16),
			'0, MODE_POS);
		send_word(CMD_STEP, MIN_Q);
		send_word(CMD_STEP, MAX_Q);
		send_word(CMD_STEP, ONE_Q);
		send_word(CMD_STEP, -ONE_Q);
		send_word(CMD_CLEAR, '1);
		send_word(CMD_STEP, 2 << 16);
		settle();

		// beta above one, crossed limits, extreme gains and set point
		cfg_write_all(MAX_Q, MIN_Q, MIN_Q, 32'h0001_FFFF, 3 << 16, 5 << 16, MAX_Q, MODE_POS);
		send_word(CMD_STEP, MIN_Q);
		send_word(CMD_STEP, '0);
		send_word(CMD_STEP, MAX_Q);
		settle();

		// switching mode keeps the shared previous error
		cfg_write_all(ONE_Q, ONE_Q >> 3, ONE_Q >> 1, BETA_ONE, 50 << 16, -(50 << 16), ONE_Q,
			MODE_INCR);
		send_word(CMD_STEP, '0);
		send_word(CMD_STEP, 3 << 16);
		send_word(CMD_STEP, -(2 << 16));
		settle();
		cfg_write(REG_CALC_MODE, MODE_POS);
		send_word(CMD_STEP, 4 << 16);
		send_word(CMD_STEP, '0);
		settle();
		cfg_write(REG_CALC_MODE, MODE_INCR);
		send_word(CMD_STEP, ONE_Q);
		send_word(CMD_CLEAR, '0);
		send_word(CMD_STEP, -ONE_Q);
		settle();

		// random phases, fresh settings each time
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			// closing phase runs with no idling on either side
			if (ph == RAND_PHASES - 1) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end else begin
				in_idle_pct = (ph % 4) * 20;
				out_idle_pct = ((ph + 2) % 4) * 20;
			end
			cfg_random();
			repeat (PHASE_WORDS)
				send_random();
			settle();
		end

		if (trk.mismatches == 0 && trk.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
